### rtl/rcl_pkg.sv
// Shared types, constants and helpers for the RC channel loss monitor.
// No dependencies; imported by every module of the block.
package rcl_pkg;

   localparam int DEF_NUM_CHANNELS = 8;

   localparam int TIMER_W     = 11;
   localparam int ELAPSED_W   = 8;
   localparam int CHANNEL_W   = 4;
   localparam int CFG_W       = 10;
   localparam int OK_W        = 8;
   localparam int VOTE_W      = 3;
   localparam int CSR_INDEX_W = 2;
   localparam int CSR_DATA_W  = 10;

   localparam logic [TIMER_W-1:0] TIMER_MAX = 11'd2047;

   localparam logic [CFG_W-1:0] RST_TIMEOUT = 10'd500;
   localparam logic [CFG_W-1:0] RST_PERIOD  = 10'd500;
   localparam logic [OK_W-1:0]  RST_MASK    = 8'h0F;

   localparam logic signed [VOTE_W-1:0] VOTE_LOSS    = 3'sd2;
   localparam logic signed [VOTE_W-1:0] VOTE_RESTORE = -3'sd2;

   localparam logic CMD_TICK = 1'b0;
   localparam logic CMD_FEED = 1'b1;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_TIMEOUT = 2'd0,
      CSR_PERIOD  = 2'd1,
      CSR_MASK    = 2'd2
   } csr_index_type;

   typedef struct packed {
      logic [CFG_W-1:0] timeout;
      logic [CFG_W-1:0] period;
      logic [OK_W-1:0]  mask;
   } cfg_type;

   typedef struct packed {
      logic                 cmd;
      logic [ELAPSED_W-1:0] elapsed;
      logic [CHANNEL_W-1:0] channel;
      logic                 armed;
   } item_type;

   typedef struct packed {
      logic lost;
      logic loss_event;
      logic restore_event;
      logic land_request;
   } vote_status_type;

   // Saturating timer add.
   function automatic logic [TIMER_W-1:0] sat_add(input logic [TIMER_W-1:0] a,
                                                   input logic [ELAPSED_W-1:0] b);
      logic [TIMER_W:0] sum;
      sum = {1'b0, a} + {{(TIMER_W + 1 - ELAPSED_W){1'b0}}, b};
      sat_add = sum[TIMER_W] ? TIMER_MAX : sum[TIMER_W-1:0];
   endfunction

endpackage

### rtl/rcl_chan_timers.sv
// Per-channel silence timers and presence bits of the RC channel loss monitor.
// Depends on rcl_pkg.
module rcl_chan_timers
   import rcl_pkg::*;
#(
   parameter int NUM_CHANNELS = DEF_NUM_CHANNELS
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   step,
   input  item_type               item,
   input  logic [CFG_W-1:0]       timeout,
   output logic [OK_W-1:0]        ok_next
);

   localparam int IDX_W = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
   localparam logic [CHANNEL_W-1:0] LAST_CH = CHANNEL_W'(NUM_CHANNELS - 1);

   logic [TIMER_W-1:0]      timer_ff [NUM_CHANNELS];
   logic [TIMER_W-1:0]      timer_in [NUM_CHANNELS];
   logic [NUM_CHANNELS-1:0] present_ff;
   logic [NUM_CHANNELS-1:0] present_in;
   logic [CHANNEL_W-1:0]    chan_clamped;
   logic [IDX_W-1:0]        feed_idx;

   // Clamp the feed channel to the last existing channel.
   always_comb begin
      chan_clamped = (item.channel > LAST_CH) ? LAST_CH : item.channel;
   end
   assign feed_idx = chan_clamped[IDX_W-1:0];

   for (genvar i = 0; i < NUM_CHANNELS; i++) begin : g_chan
      logic below;
      assign below = timer_ff[i] < {1'b0, timeout};

      always_comb begin
         timer_in[i]   = timer_ff[i];
         present_in[i] = present_ff[i];
         if (item.cmd == CMD_FEED) begin
            if (feed_idx == IDX_W'(i)) begin
               timer_in[i] = '0;
            end
         end else begin
            if (below) begin
               timer_in[i] = sat_add(timer_ff[i], item.elapsed);
            end
            present_in[i] = below;
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            timer_ff[i]   <= '0;
            present_ff[i] <= 1'b0;
         end else if (step) begin
            timer_ff[i]   <= timer_in[i];
            present_ff[i] <= present_in[i];
         end
      end
   end

   // Map presence onto the fixed-width status word; missing channels read absent.
   for (genvar b = 0; b < OK_W; b++) begin : g_ok
      if (b < NUM_CHANNELS) begin : g_have
         assign ok_next[b] = present_in[b];
      end else begin : g_none
         assign ok_next[b] = 1'b0;
      end
   end

endmodule

### rtl/rcl_link_vote.sv
// Period timer, loss vote and link-loss flag of the RC channel loss monitor.
// Depends on rcl_pkg.
module rcl_link_vote
   import rcl_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 step,
   input  item_type             item,
   input  cfg_type              cfg,
   input  logic [OK_W-1:0]      ok_next,
   output vote_status_type      status
);

   logic [TIMER_W-1:0]       period_ff, period_in, period_sum;
   logic signed [VOTE_W-1:0] vote_ff, vote_in, vote_step;
   logic                     lost_ff, lost_in;
   logic                     tick, vote_due, vote_up, loss, restore;

   assign tick = item.cmd == CMD_TICK;

   always_comb begin
      period_sum = sat_add(period_ff, item.elapsed);
      vote_due   = tick && (period_sum >= {1'b0, cfg.period});
      vote_up    = (ok_next & cfg.mask) != cfg.mask;
      vote_step  = vote_up ? (vote_ff + 3'sd1) : (vote_ff - 3'sd1);
      loss       = vote_due && (vote_step >= VOTE_LOSS);
      restore    = vote_due && (vote_step <= VOTE_RESTORE);

      period_in = period_ff;
      if (tick) begin
         period_in = vote_due ? '0 : period_sum;
      end

      vote_in = vote_ff;
      if (vote_due) begin
         vote_in = (loss || restore) ? '0 : vote_step;
      end

      lost_in = lost_ff;
      if (loss) begin
         lost_in = 1'b1;
      end else if (restore) begin
         lost_in = 1'b0;
      end

      status.lost          = lost_in;
      status.loss_event    = loss;
      status.restore_event = restore;
      status.land_request  = loss && item.armed;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         period_ff <= '0;
         vote_ff   <= '0;
         lost_ff   <= 1'b0;
      end else if (step) begin
         period_ff <= period_in;
         vote_ff   <= vote_in;
         lost_ff   <= lost_in;
      end
   end

endmodule

### rtl/rc_channel_loss_monitor.sv
// Top level of the RC channel loss monitor: handshakes, config registers, result register.
// Depends on rcl_pkg, rcl_chan_timers and rcl_link_vote.
//
// Usage:
//   req_ channel: one transaction per event. req_cmd low is a time tick carrying
//   req_elapsed_ms; req_cmd high feeds channel req_channel (clamped to the last
//   channel). req_armed qualifies the land request.
//   rsp_ channel: exactly one transaction per request, in order, carrying the
//   channel presence bits, the link-loss state and the loss/restore/land events.
//   csr_ channel: register writes (index 0 timeout, 1 check period, 2 monitored
//   mask); always ready, unknown indexes are dropped. Write only while idle.
// Ordering: a request is captured in an input register and its response is loaded
//   into the result register once the result register is empty or draining.
//   Throughput: one transaction per cycle while rsp_ready stays high, set by the
//   single update pass between the input register and the result register.
// Reset: timers, presence bits, vote and loss flag clear; registers return to
//   500 ms timeout, 500 ms check period and mask 0x0F; both pipeline stages empty.
// Stall: while rsp_ready is low the result register holds, the input register
//   holds one more transaction, and req_ready then drops.
module rc_channel_loss_monitor
   import rcl_pkg::*;
#(
   parameter int NUM_CHANNELS = DEF_NUM_CHANNELS
) (
   input  logic                   clock,
   input  logic                   reset,

   input  logic                   req_valid,
   output logic                   req_ready,
   input  logic                   req_cmd,
   input  logic [ELAPSED_W-1:0]   req_elapsed_ms,
   input  logic [CHANNEL_W-1:0]   req_channel,
   input  logic                   req_armed,

   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output logic [OK_W-1:0]        rsp_channel_ok,
   output logic                   rsp_link_lost,
   output logic                   rsp_loss_event,
   output logic                   rsp_restore_event,
   output logic                   rsp_land_request,

   input  logic                   csr_valid,
   output logic                   csr_ready,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_wdata
);

   cfg_type         cfg_ff;
   item_type        item_ff;
   logic            item_valid_ff;
   logic            rsp_valid_ff;
   logic [OK_W-1:0] ok_next;
   vote_status_type status;
   logic            out_free;
   logic            step;

   // Run the update pass when an item waits and the result register is empty or draining.
   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign step      = item_valid_ff && out_free;
   assign req_ready = !item_valid_ff || out_free;
   assign csr_ready = 1'b1;

   // Configuration registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.timeout <= RST_TIMEOUT;
         cfg_ff.period  <= RST_PERIOD;
         cfg_ff.mask    <= RST_MASK;
      end else if (csr_valid) begin
         case (csr_index_type'(csr_index))
            CSR_TIMEOUT: cfg_ff.timeout <= csr_wdata[CFG_W-1:0];
            CSR_PERIOD:  cfg_ff.period  <= csr_wdata[CFG_W-1:0];
            CSR_MASK:    cfg_ff.mask    <= csr_wdata[OK_W-1:0];
            default: begin
               // drop writes to unknown registers
            end
         endcase
      end
   end

   // Input register.
   always_ff @(posedge clock) begin
      if (reset) begin
         item_valid_ff <= 1'b0;
      end else if (req_ready) begin
         item_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         item_ff.cmd     <= req_cmd;
         item_ff.elapsed <= req_elapsed_ms;
         item_ff.channel <= req_channel;
         item_ff.armed   <= req_armed;
      end
   end

   rcl_chan_timers #(
      .NUM_CHANNELS (NUM_CHANNELS)
   ) u_timers (
      .clock   (clock),
      .reset   (reset),
      .step    (step),
      .item    (item_ff),
      .timeout (cfg_ff.timeout),
      .ok_next (ok_next)
   );

   rcl_link_vote u_vote (
      .clock   (clock),
      .reset   (reset),
      .step    (step),
      .item    (item_ff),
      .cfg     (cfg_ff),
      .ok_next (ok_next),
      .status  (status)
   );

   // Result register.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (out_free) begin
         rsp_valid_ff <= item_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (step) begin
         rsp_channel_ok    <= ok_next;
         rsp_link_lost     <= status.lost;
         rsp_loss_event    <= status.loss_event;
         rsp_restore_event <= status.restore_event;
         rsp_land_request  <= status.land_request;
      end
   end

   assign rsp_valid = rsp_valid_ff;

endmodule

### bench/rc_channel_loss_monitor_test.sv
// Self-checking bench for rc_channel_loss_monitor: directed and random feed/tick traffic
// under several register settings, with a scoreboard class that predicts every response.
// Depends on rcl_pkg and the rc_channel_loss_monitor RTL only.
module rc_channel_loss_monitor_test
   import rcl_pkg::*;
;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int CHANNELS     = DEF_NUM_CHANNELS;
   localparam int CLOCK_PERIOD = 4;
   // Cycles without any accepted transaction before the run is declared hung.
   // Longest legal quiet stretch is a sender gap or a receiver stall.
   localparam int HANG_LIMIT   = 2000;
   localparam int PHASE_ITEMS  = 255;
   // Index with no register behind it; the block must drop writes to it.
   localparam logic [CSR_INDEX_W-1:0] CSR_SPARE = 2'd3;

   typedef struct packed {
      logic [OK_W-1:0] channel_ok;
      logic            link_lost;
      logic            loss_event;
      logic            restore_event;
      logic            land_request;
   } link_status_type;

   typedef enum {EP_HEALTHY, EP_STARVED, EP_NOISE} episode_type;
   typedef enum {READY_ALWAYS, READY_PERIODIC, READY_RANDOM} ready_style_type;

   // Tracks channel silence, presence and the loss vote, and holds the
   // link status expected for every request still in flight.
   class link_status_board;
      int                timeout_ms;
      int                period_ms;
      logic [OK_W-1:0]   watched;
      int                silence_ms[CHANNELS];
      logic [OK_W-1:0]   present;
      int                since_vote;
      int                vote;
      logic              lost;
      link_status_type   due_status[$];
      int                failures;

      function new();
         timeout_ms = int'(RST_TIMEOUT);
         period_ms  = int'(RST_PERIOD);
         watched    = RST_MASK;
         foreach (silence_ms[i]) silence_ms[i] = 0;
         present    = '0;
         since_vote = 0;
         vote       = 0;
         lost       = 1'b0;
         failures   = 0;
      endfunction

      function int add_capped(int a, int b);
         return (a + b > int'(TIMER_MAX)) ? int'(TIMER_MAX) : a + b;
      endfunction

      function void set_register(logic [CSR_INDEX_W-1:0] index, logic [CSR_DATA_W-1:0] data);
         case (index)
            CSR_TIMEOUT: timeout_ms = int'(data);
            CSR_PERIOD:  period_ms  = int'(data);
            CSR_MASK:    watched    = data[OK_W-1:0];
            default: ;
         endcase
      endfunction

      function int pending();
         return due_status.size();
      endfunction

      // Advance the link state by one accepted request and queue its status.
      function void note_request(item_type it);
         link_status_type s;
         int              lane;
         s = '0;
         if (it.cmd == CMD_FEED) begin
            lane = (int'(it.channel) > CHANNELS - 1) ? CHANNELS - 1 : int'(it.channel);
            silence_ms[lane] = 0;
         end else begin
            for (int i = 0; i < CHANNELS; i++) begin
               if (silence_ms[i] < timeout_ms) begin
                  silence_ms[i] = add_capped(silence_ms[i], int'(it.elapsed));
                  present[i] = 1'b1;
               end else begin
                  present[i] = 1'b0;
               end
            end
            since_vote = add_capped(since_vote, int'(it.elapsed));
            if (since_vote >= period_ms) begin
               since_vote = 0;
               if ((present & watched) != watched) vote++;
               else vote--;
               if (vote >= int'(VOTE_LOSS)) begin
                  vote = 0;
                  lost = 1'b1;
                  s.loss_event = 1'b1;
                  s.land_request = it.armed;
               end else if (vote <= int'(VOTE_RESTORE)) begin
                  vote = 0;
                  lost = 1'b0;
                  s.restore_event = 1'b1;
               end
            end
         end
         s.channel_ok = present;
         s.link_lost  = lost;
         due_status.push_back(s);
      endfunction

      function void compare_field(string name, logic [OK_W-1:0] expected,
                                  logic [OK_W-1:0] actual);
         if (actual !== expected) begin
            $error("%s: expected 0x%0h, got 0x%0h", name, expected, actual);
            failures++;
         end
      endfunction

      function void check_response(link_status_type seen);
         link_status_type want;
         if (due_status.size() == 0) begin
            $error("response with nothing outstanding: 0x%0h", seen);
            failures++;
            return;
         end
         want = due_status.pop_front();
         compare_field("channel_ok", want.channel_ok, seen.channel_ok);
         compare_field("link_lost", OK_W'(want.link_lost), OK_W'(seen.link_lost));
         compare_field("loss_event", OK_W'(want.loss_event), OK_W'(seen.loss_event));
         compare_field("restore_event", OK_W'(want.restore_event),
                       OK_W'(seen.restore_event));
         compare_field("land_request", OK_W'(want.land_request),
                       OK_W'(seen.land_request));
      endfunction
   endclass

   logic                   clock = 1'b0;
   logic                   reset = 1'b1;

   logic                   req_valid = 1'b0;
   logic                   req_ready;
   logic                   req_cmd = CMD_TICK;
   logic [ELAPSED_W-1:0]   req_elapsed_ms = '0;
   logic [CHANNEL_W-1:0]   req_channel = '0;
   logic                   req_armed = 1'b0;

   logic                   rsp_valid;
   logic                   rsp_ready = 1'b0;
   logic [OK_W-1:0]        rsp_channel_ok;
   logic                   rsp_link_lost;
   logic                   rsp_loss_event;
   logic                   rsp_restore_event;
   logic                   rsp_land_request;

   logic                   csr_valid = 1'b0;
   logic                   csr_ready;
   logic [CSR_INDEX_W-1:0] csr_index = '0;
   logic [CSR_DATA_W-1:0]  csr_wdata = '0;

   link_status_board board = new();
   link_status_type  seen;
   int               burst_left = 0;
   int               quiet_cycles = 0;
   ready_style_type  ready_mode = READY_ALWAYS;
   int               ready_span = 1;
   int               ready_duty = 1;
   int               ready_count = 0;

   rc_channel_loss_monitor #(.NUM_CHANNELS(CHANNELS)) uut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_cmd           (req_cmd),
      .req_elapsed_ms    (req_elapsed_ms),
      .req_channel       (req_channel),
      .req_armed         (req_armed),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_channel_ok    (rsp_channel_ok),
      .rsp_link_lost     (rsp_link_lost),
      .rsp_loss_event    (rsp_loss_event),
      .rsp_restore_event (rsp_restore_event),
      .rsp_land_request  (rsp_land_request),
      .csr_valid         (csr_valid),
      .csr_ready         (csr_ready),
      .csr_index         (csr_index),
      .csr_wdata         (csr_wdata)
   );

   always #(CLOCK_PERIOD / 2) clock = ~clock;

   // Response side: check every accepted transaction against the oldest
   // expected status, then pick the next ready level. The stall style is
   // rerolled at each multiple of the reroll interval of ready_count so that
   // ready-always stretches alternate with periodic and random back-pressure.
   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         seen.channel_ok    = rsp_channel_ok;
         seen.link_lost     = rsp_link_lost;
         seen.loss_event    = rsp_loss_event;
         seen.restore_event = rsp_restore_event;
         seen.land_request  = rsp_land_request;
         board.check_response(seen);
      end
      if (ready_count % 160 == 0) begin
         ready_mode = ready_style_type'($urandom_range(0, 2));
         ready_span = $urandom_range(2, 24);
         ready_duty = $urandom_range(1, ready_span);
      end
      ready_count++;
      case (ready_mode)
         READY_ALWAYS:   rsp_ready <= 1'b1;
         READY_PERIODIC: rsp_ready <= (ready_count % ready_span) < ready_duty;
         default:        rsp_ready <= ($urandom_range(0, 3) != 0);
      endcase
   end

   // Hang detection: any accepted transaction on any channel restarts the count.
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready) ||
          (csr_valid && csr_ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles + 1 >= HANG_LIMIT) begin
         $display("CHECK FAILED");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   function automatic item_type tick_item(int elapsed, logic armed);
      item_type it;
      it.cmd     = CMD_TICK;
      it.elapsed = ELAPSED_W'(elapsed);
      it.channel = CHANNEL_W'($urandom_range(0, 15));
      it.armed   = armed;
      return it;
   endfunction

   function automatic item_type feed_item(int channel, logic armed);
      item_type it;
      it.cmd     = CMD_FEED;
      it.elapsed = ELAPSED_W'($urandom_range(0, 255));
      it.channel = CHANNEL_W'(channel);
      it.armed   = armed;
      return it;
   endfunction

   // Present one request and hold it until accepted. Bursts of random length
   // are separated by random gaps; a zero gap keeps valid high across bursts.
   task automatic send_request(input item_type it);
      int gap;
      if (burst_left == 0) begin
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
         burst_left = $urandom_range(1, 40);
         if (gap > 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
      burst_left--;
      req_valid      <= 1'b1;
      req_cmd        <= it.cmd;
      req_elapsed_ms <= it.elapsed;
      req_channel    <= it.channel;
      req_armed      <= it.armed;
      do @(posedge clock); while (!req_ready);
      board.note_request(it);
   endtask

   // Drop valid and hold until every outstanding response is back.
   task automatic drain();
      req_valid <= 1'b0;
      while (board.pending() != 0) @(posedge clock);
   endtask

   // Leaves csr_valid high so back-to-back writes need no extra assignment;
   // the caller drops it after the last write.
   task automatic write_register(input logic [CSR_INDEX_W-1:0] index,
                                 input logic [CSR_DATA_W-1:0] data);
      csr_valid <= 1'b1;
      csr_index <= index;
      csr_wdata <= data;
      do @(posedge clock); while (!csr_ready);
      board.set_register(index, data);
   endtask

   // Random traffic in episodes: healthy rounds feed every watched channel
   // and then tick, starved stretches mostly tick, noise is fully random.
   task automatic run_phase(input int count);
      episode_type kind;
      int          sent;
      int          span;
      int          lane;
      int          cap;
      int          elapsed;
      logic        armed;
      sent = 0;
      while (sent < count) begin
         case ($urandom_range(0, 9))
            0, 1, 2, 3: kind = EP_HEALTHY;
            4, 5, 6:    kind = EP_STARVED;
            default:    kind = EP_NOISE;
         endcase
         span  = $urandom_range(10, 60);
         armed = 1'($urandom_range(0, 1));
         lane  = 0;
         case ($urandom_range(0, 3))
            0:       cap = 3;
            1:       cap = 15;
            2:       cap = 63;
            default: cap = 255;
         endcase
         for (int k = 0; k < span && sent < count; k++) begin
            elapsed = ($urandom_range(0, 15) == 0) ? 255 : $urandom_range(0, cap);
            case (kind)
               EP_HEALTHY: begin
                  if (lane < CHANNELS) begin
                     if (board.watched[lane] || $urandom_range(0, 1) == 1) begin
                        // sometimes reach the last channel through an out-of-range number
                        if (lane == CHANNELS - 1 && $urandom_range(0, 1) == 1)
                           send_request(feed_item($urandom_range(CHANNELS, 15), armed));
                        else
                           send_request(feed_item(lane, armed));
                        sent++;
                     end
                     lane++;
                  end else begin
                     send_request(tick_item(elapsed, armed));
                     sent++;
                     lane = 0;
                  end
               end
               EP_STARVED: begin
                  if ($urandom_range(0, 7) == 0)
                     send_request(feed_item($urandom_range(0, 15), armed));
                  else
                     send_request(tick_item(elapsed, armed));
                  sent++;
               end
               default: begin
                  if ($urandom_range(0, 1) == 1)
                     send_request(feed_item($urandom_range(0, 15),
                                            1'($urandom_range(0, 1))));
                  else
                     send_request(tick_item($urandom_range(0, 255),
                                            1'($urandom_range(0, 1))));
                  sent++;
               end
            endcase
         end
      end
   endtask

   initial begin
      int                    t_ms;
      int                    p_ms;
      logic [CSR_DATA_W-1:0] mask_word;

      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // Reset settings: 500 ms timeout and period, channels 0..3 watched.
      // Feed both ends of the channel range, then tick at full elapsed time
      // until the vote has gone down once and up twice.
      send_request(tick_item(0, 1'b0));
      send_request(feed_item(0, 1'b1));
      send_request(feed_item(15, 1'b1));
      send_request(feed_item(8, 1'b0));
      repeat (6) send_request(tick_item(255, 1'b0));
      drain();

      // Short timeout, vote on every nonzero tick, all channels watched: loss with
      // and without arming, a repeated loss, a zero-length tick, then feed
      // every channel and recover.
      write_register(CSR_TIMEOUT, CSR_DATA_W'(20));
      write_register(CSR_PERIOD, CSR_DATA_W'(1));
      write_register(CSR_MASK, CSR_DATA_W'(8'hFF));
      csr_valid <= 1'b0;
      send_request(tick_item(255, 1'b1));
      send_request(tick_item(255, 1'b1));
      send_request(tick_item(0, 1'b1));
      send_request(tick_item(1, 1'b1));
      send_request(tick_item(1, 1'b0));
      send_request(tick_item(1, 1'b0));
      for (int ch = 0; ch < CHANNELS - 1; ch++) send_request(feed_item(ch, 1'b0));
      send_request(feed_item(12, 1'b0));
      send_request(tick_item(5, 1'b0));
      send_request(tick_item(5, 1'b0));

      for (int phase = 0; phase < 6; phase++) begin
         drain();
         case (phase)
            0: begin
               // zero timeout and zero period: all absent, vote every tick
               t_ms = 0;
               p_ms = 0;
               mask_word = 10'h3FF;
            end
            1: begin
               // register maximum, nothing watched
               t_ms = 1023;
               p_ms = 1023;
               mask_word = 10'h300;
            end
            2: begin
               t_ms = 1;
               p_ms = 1;
               mask_word = CSR_DATA_W'($urandom_range(0, 1023));
            end
            3: begin
               t_ms = $urandom_range(2, 60);
               p_ms = $urandom_range(2, 60);
               mask_word = CSR_DATA_W'($urandom_range(0, 1023));
            end
            4: begin
               t_ms = $urandom_range(20, 200);
               p_ms = $urandom_range(20, 200);
               mask_word = CSR_DATA_W'($urandom_range(0, 1023));
            end
            default: begin
               t_ms = 1000;
               p_ms = 1000;
               mask_word = 10'h00F;
            end
         endcase
         write_register(CSR_TIMEOUT, CSR_DATA_W'(t_ms));
         write_register(CSR_PERIOD, CSR_DATA_W'(p_ms));
         write_register(CSR_MASK, mask_word);
         if (phase == 3)
            write_register(CSR_SPARE, CSR_DATA_W'($urandom_range(0, 1023)));
         csr_valid <= 1'b0;
         run_phase(PHASE_ITEMS);
      end

      // Let the pipeline settle so a stray extra response would be caught.
      drain();
      repeat (8) @(posedge clock);
      if (board.failures == 0 && board.pending() == 0)
         $display("CHECK OK");
      else
         $display("CHECK FAILED");
      $finish;
   end

endmodule

### rc_channel_loss_monitor.f
rtl/rcl_pkg.sv
rtl/rcl_chan_timers.sv
rtl/rcl_link_vote.sv
rtl/rc_channel_loss_monitor.sv
bench/rc_channel_loss_monitor_test.sv
